// ===== rtl/fslw_pkg.sv =====
package fslw_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_W        = 10;
  localparam int LIMIT_W        = 10;
  localparam int MAP_W          = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 10;
  localparam logic [MAP_W-1:0] MAP_RESET = 10'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [MAP_W-1:0] w;
    logic [MAP_W-1:0] h;
  } map_cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic                      stop;
    logic [LIMIT_W-1:0]        limit;
    logic                      allow;
    logic                      same;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQRT,
    F_LOAD,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WALK,
    B_FLUSH
  } back_state_e;

endpackage

// ===== rtl/fslw_in_if.sv =====
interface fslw_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fslw_pkg::COORD_W-1:0] origin_x;
  logic signed [fslw_pkg::COORD_W-1:0] origin_y;
  logic signed [fslw_pkg::COORD_W-1:0] target_x;
  logic signed [fslw_pkg::COORD_W-1:0] target_y;
  logic                                stop_at_target;
  logic [fslw_pkg::LIMIT_W-1:0]        travel_limit;
  logic                                allow_outside;

  modport source (output valid, origin_x, origin_y, target_x, target_y, stop_at_target,
                  travel_limit, allow_outside, input ready);
  modport sink (input valid, origin_x, origin_y, target_x, target_y, stop_at_target,
                travel_limit, allow_outside, output ready);
endinterface

// ===== rtl/fslw_out_if.sv =====
interface fslw_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fslw_pkg::COORD_W-1:0] point_x;
  logic signed [fslw_pkg::COORD_W-1:0] point_y;
  logic                                point_valid;
  logic                                last_point;

  modport source (output valid, point_x, point_y, point_valid, last_point, input ready);
  modport sink (input valid, point_x, point_y, point_valid, last_point, output ready);
endinterface

// ===== rtl/fslw_front.sv =====
module fslw_front #(
  parameter int FRAC_BITS = fslw_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fslw_in_if.sink                     in_ch,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output fslw_pkg::job_t              job_o,
  output logic signed [FRAC_BITS-1:0] ix_o,
  output logic signed [FRAC_BITS-1:0] iy_o
);

  localparam int SQ_W  = 38;
  localparam int H_W   = 19;
  localparam int DEN_W = 25;
  localparam int DW    = FRAC_BITS + 20;
  localparam int CNT_W = $clog2(DW);

  fslw_pkg::front_state_e state_q, state_d;
  fslw_pkg::job_t         job_q;
  logic signed [10:0]     dx_q, dy_q;
  logic [SQ_W-1:0]        v_q, res_q, bit_q;
  logic                   axis_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [DEN_W-1:0]       den2_q, rem_q;
  logic [DW-1:0]          dvd_q, quo_q;
  logic signed [FRAC_BITS-1:0] ix_q, iy_q;

  logic               acc;
  logic signed [10:0] dx_n, dy_n;
  logic [21:0]        sq_n;
  logic [SQ_W-1:0]    trial;
  logic [H_W-1:0]     h;
  logic [DEN_W-1:0]   den_ext;
  logic signed [10:0] d_sel;
  logic [10:0]        mag;
  logic [DEN_W:0]     r_try;
  logic               qbit;
  logic [DW-1:0]      quo_n;
  logic signed [FRAC_BITS-1:0] inc;
  logic               div_last;

  assign acc  = in_ch.valid && in_ch.ready;
  assign dx_n = 11'(in_ch.target_x) - 11'(in_ch.origin_x);
  assign dy_n = 11'(in_ch.target_y) - 11'(in_ch.origin_y);
  assign sq_n = 22'(dx_n * dx_n) + 22'(dy_n * dy_n);

  assign trial   = res_q + bit_q;
  assign h       = res_q[H_W-1:0];
  assign den_ext = (DEN_W'(h) << 4) + (DEN_W'(h) << 3) + DEN_W'(h);
  assign d_sel   = axis_q ? dy_q : dx_q;
  assign mag     = d_sel[10] ? 11'(-d_sel) : 11'(d_sel);

  assign r_try    = {rem_q, dvd_q[DW-1]};
  assign qbit     = r_try >= {1'b0, den2_q};
  assign quo_n    = {quo_q[DW-2:0], qbit};
  assign inc      = d_sel[10] ? -$signed(quo_n[FRAC_BITS-1:0])
                              : $signed(quo_n[FRAC_BITS-1:0]);
  assign div_last = cnt_q == CNT_W'(DW - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      fslw_pkg::F_IDLE: if (acc) state_d = (dx_n == 0 && dy_n == 0) ? fslw_pkg::F_PUSH
                                                                     : fslw_pkg::F_SQRT;
      fslw_pkg::F_SQRT: if (bit_q[0]) state_d = fslw_pkg::F_LOAD;
      fslw_pkg::F_LOAD: state_d = fslw_pkg::F_DIV;
      fslw_pkg::F_DIV:  if (div_last) state_d = axis_q ? fslw_pkg::F_PUSH : fslw_pkg::F_LOAD;
      fslw_pkg::F_PUSH: if (job_ready_i) state_d = fslw_pkg::F_IDLE;
      default:          state_d = fslw_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = state_q == fslw_pkg::F_IDLE;
    job_valid_o = state_q == fslw_pkg::F_PUSH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fslw_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      fslw_pkg::F_IDLE: begin
        if (acc) begin
          job_q.ox    <= in_ch.origin_x;
          job_q.oy    <= in_ch.origin_y;
          job_q.tx    <= in_ch.target_x;
          job_q.ty    <= in_ch.target_y;
          job_q.stop  <= in_ch.stop_at_target;
          job_q.limit <= in_ch.travel_limit;
          job_q.allow <= in_ch.allow_outside;
          job_q.same  <= dx_n == 0 && dy_n == 0;
          dx_q        <= dx_n;
          dy_q        <= dy_n;
          v_q         <= SQ_W'(sq_n) << 16;
          res_q       <= '0;
          bit_q       <= SQ_W'(1) << 36;
          axis_q      <= 1'b0;
          ix_q        <= '0;
          iy_q        <= '0;
        end
      end
      fslw_pkg::F_SQRT: begin
        if (v_q >= trial) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      fslw_pkg::F_LOAD: begin
        // dividend 2*num + den, divisor 2*den, gives round half away
        den2_q <= den_ext << 1;
        dvd_q  <= (DW'(mag) << (FRAC_BITS + 9)) + DW'(den_ext);
        rem_q  <= '0;
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      fslw_pkg::F_DIV: begin
        rem_q <= qbit ? DEN_W'(r_try - {1'b0, den2_q}) : r_try[DEN_W-1:0];
        dvd_q <= dvd_q << 1;
        quo_q <= quo_n;
        cnt_q <= cnt_q + 1'b1;
        if (div_last) begin
          if (axis_q) iy_q <= inc;
          else        ix_q <= inc;
          axis_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign job_o = job_q;
  assign ix_o  = ix_q;
  assign iy_o  = iy_q;

endmodule

// ===== rtl/fslw_queue.sv =====
module fslw_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wp_q] <= wr_data_i;
  end

endmodule

// ===== rtl/fslw_back.sv =====
module fslw_back #(
  parameter int MAX_POINTS = fslw_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = fslw_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  input  fslw_pkg::job_t              job_i,
  input  logic signed [FRAC_BITS-1:0] ix_i,
  input  logic signed [FRAC_BITS-1:0] iy_i,
  input  fslw_pkg::map_cfg_t          map_i,
  fslw_out_if.source                  out_ch
);

  localparam int PW = FRAC_BITS + 12;
  localparam int CW = 12;
  localparam int NW = $clog2(MAX_POINTS + 1);

  fslw_pkg::back_state_e state_q, state_d;
  fslw_pkg::job_t        job_q;
  logic signed [PW-1:0]  px_q, py_q, ix_q, iy_q;
  logic signed [9:0]     lx_q, ly_q;
  logic                  have_q;
  logic [NW-1:0]         n_q;
  logic                  ov_q, opv_q, olast_q;
  logic signed [9:0]     ox_q, oy_q;

  logic                  ofree, acc;
  logic signed [PW-1:0]  px_n, py_n;
  logic signed [CW-1:0]  cx, cy, ax, ay, cheb;
  logic                  oor, outmap, newc, full, hit, far, halt, push_old;

  assign ofree = !ov_q || out_ch.ready;
  assign acc   = job_valid_i && job_ready_o;

  assign px_n = px_q + ix_q;
  assign py_n = py_q + iy_q;
  assign cx   = px_n[PW-1:FRAC_BITS];
  assign cy   = py_n[PW-1:FRAC_BITS];

  assign oor    = cx < -12'sd512 || cx > 12'sd511 || cy < -12'sd512 || cy > 12'sd511;
  assign outmap = !job_q.allow && (cx < 0 || cy < 0 ||
                  cx >= $signed({2'b00, map_i.w}) || cy >= $signed({2'b00, map_i.h}));
  assign newc   = !have_q || cx[9:0] != lx_q || cy[9:0] != ly_q;
  assign full   = newc && (n_q + 1'b1) >= NW'(MAX_POINTS);
  assign hit    = job_q.stop && cx[9:0] == job_q.tx && cy[9:0] == job_q.ty;
  assign ax     = (cx - CW'(job_q.ox)) < 0 ? CW'(job_q.ox) - cx : cx - CW'(job_q.ox);
  assign ay     = (cy - CW'(job_q.oy)) < 0 ? CW'(job_q.oy) - cy : cy - CW'(job_q.oy);
  assign cheb   = ax > ay ? ax : ay;
  assign far    = cheb >= $signed({2'b00, job_q.limit});
  assign halt   = oor || outmap || full || hit || far;
  assign push_old = state_q == fslw_pkg::B_WALK && ofree && !oor && !outmap && newc && have_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fslw_pkg::B_IDLE:  if (acc) state_d = job_i.same ? fslw_pkg::B_FLUSH : fslw_pkg::B_WALK;
      fslw_pkg::B_WALK:  if (ofree && halt) state_d = fslw_pkg::B_FLUSH;
      fslw_pkg::B_FLUSH: if (ofree) state_d = fslw_pkg::B_IDLE;
      default:           state_d = fslw_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o        = state_q == fslw_pkg::B_IDLE;
    out_ch.valid       = ov_q;
    out_ch.point_x     = ox_q;
    out_ch.point_y     = oy_q;
    out_ch.point_valid = opv_q;
    out_ch.last_point  = olast_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fslw_pkg::B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push_old || (state_q == fslw_pkg::B_FLUSH && ofree)) ov_q <= 1'b1;
      else if (out_ch.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      fslw_pkg::B_IDLE: begin
        if (acc) begin
          job_q  <= job_i;
          ix_q   <= PW'(ix_i);
          iy_q   <= PW'(iy_i);
          // start at the centre of the origin cell
          px_q   <= (PW'(job_i.ox) <<< FRAC_BITS) + (PW'(1) << (FRAC_BITS - 1));
          py_q   <= (PW'(job_i.oy) <<< FRAC_BITS) + (PW'(1) << (FRAC_BITS - 1));
          lx_q   <= job_i.ox;
          ly_q   <= job_i.oy;
          have_q <= job_i.same;
          n_q    <= '0;
        end
      end
      fslw_pkg::B_WALK: begin
        if (ofree) begin
          px_q <= px_n;
          py_q <= py_n;
          if (push_old) begin
            ox_q    <= lx_q;
            oy_q    <= ly_q;
            opv_q   <= 1'b1;
            olast_q <= 1'b0;
          end
          if (!oor && !outmap && newc) begin
            lx_q   <= cx[9:0];
            ly_q   <= cy[9:0];
            have_q <= 1'b1;
            n_q    <= n_q + 1'b1;
          end
        end
      end
      fslw_pkg::B_FLUSH: begin
        if (ofree) begin
          ox_q    <= have_q ? lx_q : '0;
          oy_q    <= have_q ? ly_q : '0;
          opv_q   <= have_q;
          olast_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/fractional_step_line_walker_core.sv =====
// Fixed-point DDA line walker: each request yields the grid cells from the origin toward the
// target in 0.04-cell sub-steps, one result per new cell, last_point on the final one, and a
// single point_valid 0 result for an empty line. A front unit computes the step increments
// with a bit-serial square root and a shared restoring divider run once per axis; the back
// unit then advances one sub-step per cycle while the output is not stalled. A two-entry
// queue between them lets the setup of the next request overlap the walk of the current one.
module fractional_step_line_walker_core #(
  parameter int MAX_POINTS = fslw_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = fslw_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fslw_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fslw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  fslw_in_if.sink                           in_ch,
  fslw_out_if.source                        out_ch
);

  localparam int QW = $bits(fslw_pkg::job_t) + 2 * FRAC_BITS;

  fslw_pkg::map_cfg_t          map_q;
  logic                        f_valid, f_ready, b_valid, b_ready;
  fslw_pkg::job_t              f_job, b_job;
  logic signed [FRAC_BITS-1:0] f_ix, f_iy, b_ix, b_iy;
  logic [QW-1:0]               q_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q.w <= fslw_pkg::MAP_RESET;
      map_q.h <= fslw_pkg::MAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fslw_pkg::REG_MAP_WIDTH:  map_q.w <= cfg_data_i;
        fslw_pkg::REG_MAP_HEIGHT: map_q.h <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fslw_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_ch,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job), .ix_o(f_ix), .iy_o(f_iy)
  );

  fslw_queue #(.WIDTH(QW)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i({f_job, f_ix, f_iy}),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(q_rd)
  );

  assign {b_job, b_ix, b_iy} = q_rd;

  fslw_back #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .ix_i(b_ix), .iy_i(b_iy), .map_i(map_q), .out_ch
  );

  // an empty-line result always closes its line
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.point_valid) |-> out_ch.last_point)
    else $error("empty-line result without last_point");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.point_valid) |-> (out_ch.point_x == 0 && out_ch.point_y == 0))
    else $error("empty-line result with nonzero cell");

  // the back unit only takes a job it can hold
  a_back_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_ready && b_valid) |=> !b_ready)
    else $error("back unit took a job while busy");

endmodule
